@@ src/ltmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ltmd_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned IdW     = 14;
   localparam int unsigned LenW    = 24;
   localparam int unsigned LenCntW = 2;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_HDR_HI  = 4'b0001,
      PH_HDR_LO  = 4'b0010,
      PH_LEN     = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [IdW-1:0]   message_id;
      logic [ByteW-1:0] payload_byte;
      logic             has_byte;
      logic             last;
      logic [LenW-1:0]  payload_length;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/length_type_message_deframer_core.sv @@
// A byte passes from the input register through the phase machine to the result register.
// Throughput: one byte per cycle unless a result waits on a stalled output; the phase machine
// updates in a single pass between the input register and the result register.
// Header and length bytes produce no result, so never wait, save one ending an empty message.
// Reset is synchronous and active high; it empties both registers and
// returns the parser to waiting for a header.
`timescale 1ns / 1ps
`default_nettype none

module length_type_message_deframer_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [ltmd_pkg::ByteW-1:0]   req_in_byte,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [ltmd_pkg::IdW-1:0]     rsp_message_id,
   output      logic [ltmd_pkg::ByteW-1:0]   rsp_payload_byte,
   output      logic                         rsp_has_byte,
   output      logic                         rsp_last,
   output      logic [ltmd_pkg::LenW-1:0]    rsp_payload_length
);
   import ltmd_pkg::*;

   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff;
   rsp_type          rsp_next;
   logic             emit;
   logic             go;

   // A byte that yields no result never waits for the output register.
   assign go        = in_valid_ff && (!emit || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;

   ltmd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte_ff),
      .go      (go),
      .emit    (emit),
      .rsp     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (go && emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && emit) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_message_id     = out_ff.message_id;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_has_byte       = out_ff.has_byte;
   assign rsp_last           = out_ff.last;
   assign rsp_payload_length = out_ff.payload_length;

endmodule

`default_nettype wire

@@ src/ltmd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ltmd_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ltmd_pkg::ByteW-1:0] in_byte,
   input  wire logic                  go,
   output      logic                  emit,
   output      ltmd_pkg::rsp_type     rsp
);
   import ltmd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [ByteW-1:0]       header_high_ff, header_high_in;
   logic [IdW-1:0]         current_id_ff, current_id_in;
   logic [LenCntW-1:0]     len_left_ff, len_left_in;
   logic [LenW-1:0]        len_accum_ff, len_accum_in;
   logic [LenW-1:0]        payload_left_ff, payload_left_in;

   always_comb begin
      phase_in        = phase_ff;
      header_high_in  = header_high_ff;
      current_id_in   = current_id_ff;
      len_left_in     = len_left_ff;
      len_accum_in    = len_accum_ff;
      payload_left_in = payload_left_ff;
      emit            = 1'b0;
      rsp.message_id     = current_id_ff;
      rsp.payload_byte   = '0;
      rsp.has_byte       = 1'b0;
      rsp.last           = 1'b1;
      rsp.payload_length = len_accum_ff;
      unique case (phase_ff)
         PH_HDR_LO: begin
            current_id_in   = {header_high_ff, in_byte[ByteW-1:LenCntW]};
            len_left_in     = in_byte[LenCntW-1:0];
            len_accum_in    = '0;
            payload_left_in = '0;
            rsp.message_id     = current_id_in;
            rsp.payload_length = '0;
            if (len_left_in == '0) begin
               // No length bytes: the empty-message marker goes out at once.
               phase_in = PH_HDR_HI;
               emit     = 1'b1;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            len_accum_in = {len_accum_ff[LenW-ByteW-1:0], in_byte};
            len_left_in  = len_left_ff - LenCntW'(1);
            rsp.payload_length = len_accum_in;
            if (len_left_in == '0) begin
               if (len_accum_in == '0) begin
                  phase_in = PH_HDR_HI;
                  emit     = 1'b1;
               end else begin
                  payload_left_in = len_accum_in;
                  phase_in        = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            payload_left_in  = payload_left_ff - LenW'(1);
            emit             = 1'b1;
            rsp.payload_byte = in_byte;
            rsp.has_byte     = 1'b1;
            rsp.last         = (payload_left_in == '0);
            if (payload_left_in == '0) begin
               phase_in = PH_HDR_HI;
            end
         end
         default: begin
            // Header high byte; unused codes fall here as well.
            header_high_in = in_byte;
            phase_in       = PH_HDR_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR_HI;
         len_left_ff     <= '0;
         payload_left_ff <= '0;
      end else if (go) begin
         phase_ff        <= phase_in;
         len_left_ff     <= len_left_in;
         payload_left_ff <= payload_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         header_high_ff <= header_high_in;
         current_id_ff  <= current_id_in;
         len_accum_ff   <= len_accum_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ltmd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ltmd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [ltmd_pkg::IdW-1:0]     rsp_message_id,
   input wire logic [ltmd_pkg::ByteW-1:0]   rsp_payload_byte,
   input wire logic                         rsp_has_byte,
   input wire logic                         rsp_last,
   input wire logic [ltmd_pkg::LenW-1:0]    rsp_payload_length
);
   import ltmd_pkg::*;

   // The block comes out of reset with nothing to deliver.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The input is only held off while a result waits on a stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a waiting result");

   // An empty-message marker is always the final transaction of its message.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_last && rsp_payload_byte == '0
                                        && rsp_payload_length == '0))
      else $error("malformed empty-message marker");

   // A payload byte belongs to a message of non-zero length.
   a_byte_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_byte) |-> (rsp_payload_length != '0))
      else $error("payload byte with zero length");

   // A stalled result stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_message_id)
         && $stable(rsp_payload_byte) && $stable(rsp_has_byte)
         && $stable(rsp_last) && $stable(rsp_payload_length)))
      else $error("stalled result changed");

endmodule

bind length_type_message_deframer_core ltmd_checker u_ltmd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_message_id     (rsp_message_id),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_has_byte       (rsp_has_byte),
   .rsp_last           (rsp_last),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire
